>>> rtl/recbq_pkg.sv
// Package for the rotary encoder and button qualifier.
// Holds widths, reset values, code constants and the configuration struct.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package recbq_pkg;

   // Internal widths of the time arithmetic and of the position counter.
   localparam int TIME_BITS     = 32;
   localparam int POSITION_BITS = 16;

   // Fixed payload widths of the channels.
   localparam int TIME_W    = 32;
   localparam int ROT_W     = 2;
   localparam int POS_W     = 16;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BTN_DEBOUNCE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD         = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [CFG_W-1:0] ROT_DEBOUNCE_RESET = 16'd5;
   localparam logic [CFG_W-1:0] BTN_DEBOUNCE_RESET = 16'd50;
   localparam logic [CFG_W-1:0] HOLD_RESET         = 16'd1000;

   // Rotation codes, two's complement.
   localparam logic signed [ROT_W-1:0] ROT_NONE = 2'sb00;
   localparam logic signed [ROT_W-1:0] ROT_CW   = 2'sb01;
   localparam logic signed [ROT_W-1:0] ROT_CCW  = 2'sb11;

   typedef struct packed {
      logic [CFG_W-1:0] rot_debounce_ms;
      logic [CFG_W-1:0] btn_debounce_ms;
      logic [CFG_W-1:0] hold_ms;
   } cfg_type;

endpackage

`default_nettype wire

>>> rtl/recbq_if.sv
// Channel interfaces of the rotary encoder and button qualifier:
// poll request, result response and configuration write.
// Depends on recbq_pkg.
`default_nettype none

interface recbq_req_if;
   import recbq_pkg::*;

   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] time_ms;
   logic              clk_level;
   logic              dt_level;
   logic              button_level;

   modport source (output valid, time_ms, clk_level, dt_level, button_level, input ready);
   modport sink   (input valid, time_ms, clk_level, dt_level, button_level, output ready);
endinterface

interface recbq_rsp_if;
   import recbq_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [ROT_W-1:0] rotation;
   logic                    press_event;
   logic                    held;
   logic signed [POS_W-1:0] position;

   modport source (output valid, rotation, press_event, held, position, input ready);
   modport sink   (input valid, rotation, press_event, held, position, output ready);
endinterface

interface recbq_csr_if;
   import recbq_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

>>> rtl/recbq_csr.sv
// Configuration registers of the rotary encoder and button qualifier.
// Depends on recbq_pkg and recbq_csr_if.
`default_nettype none

module recbq_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   recbq_csr_if.sink            csr_chan,
   output recbq_pkg::cfg_type   cfg
);
   import recbq_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   // Writes are always taken; an index beyond the list is dropped.
   assign csr_chan.ready = 1'b1;
   assign wr_en          = csr_chan.valid && csr_chan.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_chan.index)
            CSR_ROT_DEBOUNCE: cfg_in.rot_debounce_ms = csr_chan.wdata;
            CSR_BTN_DEBOUNCE: cfg_in.btn_debounce_ms = csr_chan.wdata;
            CSR_HOLD:         cfg_in.hold_ms         = csr_chan.wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rot_debounce_ms <= ROT_DEBOUNCE_RESET;
         cfg_ff.btn_debounce_ms <= BTN_DEBOUNCE_RESET;
         cfg_ff.hold_ms         <= HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> rtl/rotary_encoder_button_qualifier.sv
// Top level of the rotary encoder and button qualifier.
// Depends on recbq_pkg, the channel interfaces in recbq_if and recbq_csr.
//
//   Channel   Dir  Payload                                        Handshake
//   req_chan  in   time_ms, clk_level, dt_level, button_level     valid/ready
//   rsp_chan  out  rotation, press_event, held, position          valid/ready
//   csr_chan  in   index, wdata (rotation/button debounce, hold)  valid/ready
//
// One poll per clock is sustained unless the response stalls. A poll is
// registered at its transfer, evaluated by one level of compare and add logic
// in the next cycle, and its result is loaded into the output register when
// that register is free. The poll and result registers each hold one item, so
// a stalled response only stops input once both are full. Reset is synchronous
// and returns the encoder, button and configuration state to the reset values.
`default_nettype none

module rotary_encoder_button_qualifier (
   input  wire logic  clock,
   input  wire logic  reset,
   recbq_req_if.sink  req_chan,
   recbq_rsp_if.source rsp_chan,
   recbq_csr_if.sink  csr_chan
);
   import recbq_pkg::*;

   cfg_type cfg;

   recbq_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // ---------------------------------------------------------------------
   // Poll register. It takes a new poll whenever it is empty or its
   // current poll moves on to the result register in the same cycle.
   // ---------------------------------------------------------------------
   logic                 in_valid_ff, in_valid_in;
   logic [TIME_BITS-1:0] in_time_ff;
   logic                 in_clk_ff;
   logic                 in_dt_ff;
   logic                 in_btn_ff;
   logic                 req_xfer;
   logic                 advance;
   logic                 rsp_valid_ff, rsp_valid_in;

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign in_valid_in    = req_xfer || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_time_ff <= TIME_BITS'(req_chan.time_ms);
         in_clk_ff  <= req_chan.clk_level;
         in_dt_ff   <= req_chan.dt_level;
         in_btn_ff  <= req_chan.button_level;
      end
   end

   // ---------------------------------------------------------------------
   // Qualifier state. It is updated only when a poll advances, so the
   // next poll in the poll register always sees the state left by the one
   // before it.
   // ---------------------------------------------------------------------
   logic                     prev_clk_ff,       prev_clk_in;
   logic                     prev_btn_ff,       prev_btn_in;
   logic [TIME_BITS-1:0]     debounce_stamp_ff, debounce_stamp_in;
   logic [TIME_BITS-1:0]     press_stamp_ff,    press_stamp_in;
   logic                     is_pressed_ff,     is_pressed_in;
   logic [POSITION_BITS-1:0] step_count_ff,     step_count_in;

   // Elapsed times are modular differences at the internal time width.
   logic [TIME_BITS-1:0] since_debounce;
   logic [TIME_BITS-1:0] since_press;
   logic                 clk_change;
   logic                 rot_ok;
   logic                 btn_fall;
   logic                 btn_rise;
   logic                 press_ok;
   logic                 held_now;
   logic signed [ROT_W-1:0] rotation_now;

   assign since_debounce = in_time_ff - debounce_stamp_ff;
   assign since_press    = in_time_ff - press_stamp_ff;

   assign clk_change = in_clk_ff != prev_clk_ff;
   assign rot_ok     = clk_change && (since_debounce > TIME_BITS'(cfg.rot_debounce_ms));

   assign btn_fall = !in_btn_ff && prev_btn_ff;
   assign btn_rise = in_btn_ff && !prev_btn_ff;

   // The debounce stamp is shared. When a rotation step refreshes it in
   // this poll, the press check sees an elapsed time of zero and can never
   // pass, so the press compare runs on the old stamp gated by the step.
   assign press_ok = btn_fall && !rot_ok
                     && (since_debounce > TIME_BITS'(cfg.btn_debounce_ms));

   // Likewise a press accepted in this poll restarts the hold time at zero,
   // so held is reported only for a press taken in an earlier poll.
   assign held_now = is_pressed_in && !press_ok
                     && (since_press > TIME_BITS'(cfg.hold_ms));

   always_comb begin
      rotation_now      = ROT_NONE;
      step_count_in     = step_count_ff;
      debounce_stamp_in = debounce_stamp_ff;
      press_stamp_in    = press_stamp_ff;
      is_pressed_in     = is_pressed_ff;
      prev_clk_in       = in_clk_ff;
      prev_btn_in       = in_btn_ff;

      if (rot_ok) begin
         debounce_stamp_in = in_time_ff;
         // Data differing from clock means a clockwise detent.
         if (in_dt_ff != in_clk_ff) begin
            rotation_now  = ROT_CW;
            step_count_in = step_count_ff + POSITION_BITS'(1);
         end else begin
            rotation_now  = ROT_CCW;
            step_count_in = step_count_ff - POSITION_BITS'(1);
         end
      end

      if (press_ok) begin
         debounce_stamp_in = in_time_ff;
         press_stamp_in    = in_time_ff;
         is_pressed_in     = 1'b1;
      end else if (btn_rise) begin
         is_pressed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_clk_ff       <= 1'b1;
         prev_btn_ff       <= 1'b1;
         debounce_stamp_ff <= '0;
         press_stamp_ff    <= '0;
         is_pressed_ff     <= 1'b0;
         step_count_ff     <= '0;
      end else if (advance) begin
         prev_clk_ff       <= prev_clk_in;
         prev_btn_ff       <= prev_btn_in;
         debounce_stamp_ff <= debounce_stamp_in;
         press_stamp_ff    <= press_stamp_in;
         is_pressed_ff     <= is_pressed_in;
         step_count_ff     <= step_count_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register. It holds a result until the response transfer.
   // ---------------------------------------------------------------------
   logic signed [ROT_W-1:0] rsp_rotation_ff;
   logic                    rsp_press_ff;
   logic                    rsp_held_ff;
   logic signed [POS_W-1:0] rsp_position_ff;

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_rotation_ff <= rotation_now;
         rsp_press_ff    <= press_ok;
         rsp_held_ff     <= held_now;
         rsp_position_ff <= POS_W'(step_count_in);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.rotation    = rsp_rotation_ff;
   assign rsp_chan.press_event = rsp_press_ff;
   assign rsp_chan.held        = rsp_held_ff;
   assign rsp_chan.position    = rsp_position_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------

   // A step and a press never qualify in the same poll: they share a stamp.
   a_no_step_and_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_press_ff && (rsp_rotation_ff != ROT_NONE)))
      else $error("rotation step and press reported in the same result");

   // The poll that takes a press cannot already be held.
   a_no_held_on_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_press_ff && rsp_held_ff))
      else $error("held reported on the poll that took the press");

   // The position moves only with a reported step.
   a_position_steady: assert property (@(posedge clock) disable iff (reset)
      (advance && !rot_ok) |=> (step_count_ff == $past(step_count_ff)))
      else $error("position changed without a rotation step");

   // A poll waiting for the result register is never dropped or replaced.
   a_poll_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_time_ff)))
      else $error("stalled poll lost from the poll register");

endmodule

`default_nettype wire

>>> verif/rotary_encoder_button_qualifier_tb.sv
// Self-checking testbench for the rotary encoder and button qualifier.
// Depends on recbq_pkg, the channel interfaces in recbq_if and the top level
// rotary_encoder_button_qualifier, which needs recbq_csr as well.
`timescale 1ns / 100ps

module rotary_encoder_button_qualifier_tb;
   import recbq_pkg::*;

   // The run is cut off here; a correct run needs well under a tenth of it.
   localparam int CYCLE_LIMIT = 200000;
   // Polls per random phase; three phases give about 1300 polls.
   localparam int PHASE_ITEMS = 430;
   // Cycles allowed after the last expected reading before a config write
   // or the end.
   localparam int SETTLE_CYCLES = 4;
   localparam int SCRIPT_LEN = 31;
   // Index past the register list; a write to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   // Quadrature pin pairs {clk, dt} in rotation order, two bits per phase.
   localparam logic [7:0] QUAD_SEQ = 8'b10_00_01_11;

   typedef struct packed {
      logic [TIME_W-1:0] time_ms;
      logic              clk_level;
      logic              dt_level;
      logic              button_level;
   } poll_type;

   typedef struct packed {
      logic signed [ROT_W-1:0] rotation;
      logic                    press_event;
      logic                    held;
      logic signed [POS_W-1:0] position;
   } reading_type;

   typedef enum logic {ROW_POLL, ROW_WRITE} row_kind_type;

   // One row of the directed script. A pinned row carries a reading that is
   // typed in by hand; all other polls are checked against the predictor.
   typedef struct packed {
      row_kind_type         kind;
      poll_type             poll;
      logic [CSR_IDX_W-1:0] index;
      logic [CFG_W-1:0]     wdata;
      logic                 pinned;
      reading_type          reading;
   } script_row_type;

   logic clock;
   logic reset;

   recbq_req_if req_bus ();
   recbq_rsp_if rsp_bus ();
   recbq_csr_if csr_bus ();

   rotary_encoder_button_qualifier dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Predictor state: a private copy of the encoder, button and settings.
   logic [CFG_W-1:0]  rot_window    = ROT_DEBOUNCE_RESET;
   logic [CFG_W-1:0]  press_window  = BTN_DEBOUNCE_RESET;
   logic [CFG_W-1:0]  hold_window   = HOLD_RESET;
   logic              last_clk      = 1'b1;
   logic              last_button   = 1'b1;
   logic [TIME_W-1:0] shared_stamp  = '0;
   logic [TIME_W-1:0] press_time    = '0;
   logic              pressed       = 1'b0;
   logic [POS_W-1:0]  step_total    = '0;

   reading_type pending_readings [$];
   int          faults = 0;
   int          cycles = 0;
   int          src_idle_pct = 6;
   int          sink_idle_pct = 61;

   // Set by the poll driver before a transfer, read by the monitor at it.
   logic        pin_active = 1'b0;
   reading_type pin_reading = '0;

   // Predicts the reading of one poll and advances the predictor state.
   // Elapsed times are plain unsigned differences at the time width: a timestamp
   // that wrapped still gives the true gap, one that went backwards a large gap.
   function automatic reading_type qualify_poll(poll_type p);
      reading_type       r;
      logic [TIME_W-1:0] gap;
      r = '0;
      r.rotation = ROT_NONE;
      if (p.clk_level != last_clk) begin
         gap = p.time_ms - shared_stamp;
         if (gap > TIME_W'(rot_window)) begin
            if (p.dt_level != p.clk_level) begin
               step_total = step_total + POS_W'(1);
               r.rotation = ROT_CW;
            end else begin
               step_total = step_total - POS_W'(1);
               r.rotation = ROT_CCW;
            end
            shared_stamp = p.time_ms;
         end
      end
      last_clk = p.clk_level;
      // The button sees the stamp as rotation left it in this same poll.
      if (!p.button_level && last_button) begin
         gap = p.time_ms - shared_stamp;
         if (gap > TIME_W'(press_window)) begin
            shared_stamp = p.time_ms;
            press_time = p.time_ms;
            pressed = 1'b1;
            r.press_event = 1'b1;
         end
      end else if (p.button_level && !last_button) begin
         pressed = 1'b0;
      end
      last_button = p.button_level;
      gap = p.time_ms - press_time;
      r.held = pressed && (gap > TIME_W'(hold_window));
      r.position = step_total;
      return r;
   endfunction

   function automatic script_row_type poll_row(logic [TIME_W-1:0] t, logic c, logic d,
                                               logic b);
      script_row_type row;
      row = '0;
      row.kind = ROW_POLL;
      row.poll = '{t, c, d, b};
      return row;
   endfunction

   function automatic script_row_type pinned_row(logic [TIME_W-1:0] t, logic c, logic d,
                                                 logic b, logic signed [ROT_W-1:0] rot,
                                                 logic press, logic hold,
                                                 logic signed [POS_W-1:0] pos);
      script_row_type row;
      row = poll_row(t, c, d, b);
      row.pinned = 1'b1;
      row.reading = '{rot, press, hold, pos};
      return row;
   endfunction

   function automatic script_row_type write_row(logic [CSR_IDX_W-1:0] idx,
                                                logic [CFG_W-1:0] data);
      script_row_type row;
      row = '0;
      row.kind = ROW_WRITE;
      row.index = idx;
      row.wdata = data;
      return row;
   endfunction

   // Directed script, starting from the reset settings (5, 50, 1000 ms).
   script_row_type script [0:SCRIPT_LEN-1] = '{
      // Steady pins right after reset give an empty reading.
      pinned_row(32'd0, 1'b1, 1'b0, 1'b1, ROT_NONE, 1'b0, 1'b0, 16'sd0),
      // A clock change exactly at the window edge is dropped.
      pinned_row(32'd5, 1'b0, 1'b0, 1'b1, ROT_NONE, 1'b0, 1'b0, 16'sd0),
      pinned_row(32'd6, 1'b1, 1'b0, 1'b1, ROT_CW, 1'b0, 1'b0, 16'sd1),
      pinned_row(32'd12, 1'b0, 1'b0, 1'b1, ROT_CCW, 1'b0, 1'b0, 16'sd0),
      poll_row(32'd13, 1'b1, 1'b1, 1'b1),
      // Press at exactly the button window: lost until released again.
      poll_row(32'd62, 1'b1, 1'b1, 1'b0),
      poll_row(32'd200, 1'b1, 1'b1, 1'b0),
      poll_row(32'd201, 1'b1, 1'b1, 1'b1),
      poll_row(32'd202, 1'b1, 1'b1, 1'b0),
      // Held only once the hold time is strictly exceeded.
      poll_row(32'd1202, 1'b1, 1'b1, 1'b0),
      poll_row(32'd1203, 1'b1, 1'b1, 1'b0),
      poll_row(32'd1250, 1'b1, 1'b1, 1'b1),
      // Step and press in one poll: the step refreshes the shared stamp,
      // so the press in the same poll is lost.
      poll_row(32'd1300, 1'b0, 1'b1, 1'b0),
      poll_row(32'd1400, 1'b0, 1'b1, 1'b1),
      // Time wrap, then a timestamp that goes backwards.
      pinned_row(32'hFFFF_FFF0, 1'b1, 1'b1, 1'b1, ROT_CCW, 1'b0, 1'b0, 16'sd0),
      pinned_row(32'd2, 1'b0, 1'b0, 1'b1, ROT_CCW, 1'b0, 1'b0, -16'sd1),
      poll_row(32'd1, 1'b1, 1'b0, 1'b1),
      // All windows at zero, plus a write past the register list.
      write_row(CSR_ROT_DEBOUNCE, 16'h0000),
      write_row(CSR_BTN_DEBOUNCE, 16'h0000),
      write_row(CSR_HOLD, 16'h0000),
      write_row(CSR_UNUSED, 16'hFFFF),
      pinned_row(32'd1, 1'b0, 1'b0, 1'b1, ROT_NONE, 1'b0, 1'b0, 16'sd0),
      poll_row(32'd2, 1'b1, 1'b0, 1'b0),
      poll_row(32'd3, 1'b1, 1'b0, 1'b1),
      poll_row(32'd4, 1'b1, 1'b0, 1'b0),
      poll_row(32'd5, 1'b1, 1'b0, 1'b0),
      // All windows at their maximum.
      write_row(CSR_ROT_DEBOUNCE, 16'hFFFF),
      write_row(CSR_BTN_DEBOUNCE, 16'hFFFF),
      write_row(CSR_HOLD, 16'hFFFF),
      poll_row(32'h0001_0003, 1'b0, 1'b1, 1'b1),
      poll_row(32'h0001_0004, 1'b1, 1'b1, 1'b0)
   };

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Response side: ready is redrawn at every falling edge.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready = ($urandom_range(99) >= sink_idle_pct);
      end
   end

   // Monitor. At the rising edge every channel still shows the values of the
   // cycle that ends, so transfers are seen exactly as the block sees them.
   // The response is checked before this edge's poll is predicted; the poll
   // register and the result register keep them apart.
   always @(posedge clock) begin
      reading_type got;
      reading_type want;
      cycles = cycles + 1;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.rotation, rsp_bus.press_event, rsp_bus.held,
                    rsp_bus.position};
            if (pending_readings.size() == 0) begin
               $display("%0t: expected nothing, got %0d/%0b/%0b/%0d",
                        $time, got.rotation, got.press_event, got.held, got.position);
               faults = faults + 1;
            end else begin
               want = pending_readings.pop_front();
               if (got !== want) begin
                  $display("%0t: expected %0d/%0b/%0b/%0d, got %0d/%0b/%0b/%0d",
                           $time, want.rotation, want.press_event, want.held,
                           want.position, got.rotation, got.press_event, got.held,
                           got.position);
                  faults = faults + 1;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            want = qualify_poll('{req_bus.time_ms, req_bus.clk_level, req_bus.dt_level,
                                  req_bus.button_level});
            pending_readings.push_back(pin_active ? pin_reading : want);
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_ROT_DEBOUNCE: rot_window = csr_bus.wdata;
               CSR_BTN_DEBOUNCE: press_window = csr_bus.wdata;
               CSR_HOLD:         hold_window = csr_bus.wdata;
               default: ;
            endcase
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Offers one poll, with random idle cycles first, and returns at the
   // falling edge after its transfer with valid still high, so that the
   // next poll can follow back to back.
   task automatic send_poll(input poll_type p, input logic pin, input reading_type r);
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.time_ms = p.time_ms;
      req_bus.clk_level = p.clk_level;
      req_bus.dt_level = p.dt_level;
      req_bus.button_level = p.button_level;
      pin_active = pin;
      pin_reading = r;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Leaves csr valid high; the caller lowers it after the last write.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CFG_W-1:0] data);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.wdata = data;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
   endtask

   // Stops offering polls and waits until every reading has come back.
   task automatic settle_pipeline();
      req_bus.valid = 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Stimulus: directed script, then three random phases with different
   // settings and idle patterns.
   initial begin
      poll_type          p;
      logic [TIME_W-1:0] gen_time;
      logic [1:0]        gen_quad;
      logic              gen_dir;
      logic              gen_button;
      logic [1:0]        levels;
      int                roll;
      int                span;
      logic [CFG_W-1:0]  rot_cfg;
      logic [CFG_W-1:0]  btn_cfg;
      logic [CFG_W-1:0]  hold_cfg;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.time_ms = '0;
      req_bus.clk_level = 1'b1;
      req_bus.dt_level = 1'b1;
      req_bus.button_level = 1'b1;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_ROT_DEBOUNCE;
      csr_bus.wdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. Config writes come in runs; the pipeline is drained
      // before a run and csr valid is lowered after it.
      for (int i = 0; i < SCRIPT_LEN; i++) begin
         if (script[i].kind == ROW_WRITE) begin
            if (i == 0 || script[i-1].kind != ROW_WRITE) settle_pipeline();
            write_register(script[i].index, script[i].wdata);
            if (i == SCRIPT_LEN - 1 || script[i+1].kind != ROW_WRITE)
               csr_bus.valid = 1'b0;
         end else begin
            send_poll(script[i].poll, script[i].pinned, script[i].reading);
         end
      end

      gen_time = 32'h0002_0000;
      gen_quad = 2'd0;
      gen_dir = 1'b1;
      gen_button = 1'b1;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               src_idle_pct = 6;
               sink_idle_pct = 61;
               rot_cfg = 16'd3;
               btn_cfg = 16'd20;
               hold_cfg = 16'd100;
               span = 15;
            end
            1: begin
               src_idle_pct = 61;
               sink_idle_pct = 6;
               rot_cfg = 16'd0;
               btn_cfg = 16'd0;
               hold_cfg = 16'd0;
               span = 3;
            end
            default: begin
               src_idle_pct = 0;
               sink_idle_pct = 0;
               rot_cfg = CFG_W'($urandom_range(1, 12));
               btn_cfg = CFG_W'($urandom_range(1, 60));
               hold_cfg = CFG_W'($urandom_range(20, 250));
               span = $urandom_range(5, 25);
            end
         endcase
         settle_pipeline();
         write_register(CSR_ROT_DEBOUNCE, rot_cfg);
         write_register(CSR_BTN_DEBOUNCE, btn_cfg);
         write_register(CSR_HOLD, hold_cfg);
         csr_bus.valid = 1'b0;

         // Mostly a real knob: time creeps forward, the pins walk the
         // quadrature cycle and the switch is pressed for a while. A few
         // polls carry time jumps, backward time and contact bounce.
         repeat (PHASE_ITEMS) begin
            roll = $urandom_range(99);
            if (roll < 5) gen_time = $urandom;
            else if (roll < 8) gen_time = gen_time - $urandom_range(1, 40);
            else gen_time = gen_time + $urandom_range(0, span);
            p.time_ms = gen_time;

            roll = $urandom_range(99);
            if (roll < 8) gen_dir = ~gen_dir;
            if (roll < 75) gen_quad = gen_quad + (gen_dir ? 2'd1 : 2'd3);
            levels = QUAD_SEQ[{gen_quad, 1'b0} +: 2];
            if (roll >= 92) levels = 2'($urandom_range(3));
            p.clk_level = levels[1];
            p.dt_level = levels[0];

            roll = $urandom_range(99);
            if (roll < 5) gen_button = ~gen_button;
            p.button_level = (roll >= 96) ? ~gen_button : gen_button;

            send_poll(p, 1'b0, '0);
         end
      end

      settle_pipeline();
      if (faults == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
